/* design/fru_type_length_field_decoder_assert.svh */
// Assertion macros shared by the FRU type/length field decoder.
`ifndef FRU_TYPE_LENGTH_FIELD_DECODER_ASSERT_SVH
`define FRU_TYPE_LENGTH_FIELD_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRUTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRUTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/frutl_pkg.sv */
// Types, constants and character tables of the FRU type/length field decoder.
package frutl_pkg;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [7:0] CHAR_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        FT_BINARY = 2'd0,
        FT_BCD    = 2'd1,
        FT_ASCII6 = 2'd2,
        FT_ASCII8 = 2'd3
    } t_field_type;

    typedef struct packed {
        logic [23:0] word;
        t_field_type ftype;
        logic        empty;
        logic        last;
    } t_job;

    typedef struct packed {
        logic        valid;
        logic        full;
    } t_q_stat;

    localparam logic [7:0] HEX_MAP [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [7:0] BCD_MAP [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h20, 8'h2d, 8'h2e, 8'h3a, 8'h2c, 8'h5f
    };

endpackage

/* design/frutl_front.sv */
// Front end: parses type/length bytes and packs data bytes into character jobs.
module frutl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    output logic             o_job_push,
    output frutl_pkg::t_job  o_job
);

    logic [5:0]              r_bytes_left, n_bytes_left;
    frutl_pkg::t_field_type  r_type, n_type;
    logic [23:0]             r_word, n_word;
    logic [1:0]              r_gcnt, n_gcnt;
    logic [5:0]              w_left_dec;
    logic                    w_last;
    logic [23:0]             w_word_ins;
    logic [1:0]              w_gcnt_inc;

    assign w_left_dec = r_bytes_left - 6'd1;
    assign w_last     = (w_left_dec == 6'd0);
    assign w_gcnt_inc = r_gcnt + 2'd1;

    always_comb begin
        w_word_ins = r_word;
        case (r_gcnt)
            2'd0: w_word_ins[7:0]   = i_data_byte;
            2'd1: w_word_ins[15:8]  = i_data_byte;
            2'd2: w_word_ins[23:16] = i_data_byte;
            default: w_word_ins = r_word;
        endcase
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_type       = r_type;
        n_word       = r_word;
        n_gcnt       = r_gcnt;
        o_job_push   = 1'b0;
        o_job.word   = {16'd0, i_data_byte};
        o_job.ftype  = r_type;
        o_job.empty  = 1'b0;
        o_job.last   = w_last;
        if (i_accept) begin
            if (r_bytes_left == 6'd0) begin
                n_type       = frutl_pkg::t_field_type'(i_data_byte[7:6]);
                n_bytes_left = i_data_byte[5:0];
                n_word       = 24'd0;
                n_gcnt       = 2'd0;
                o_job.word   = 24'd0;
                o_job.ftype  = frutl_pkg::t_field_type'(i_data_byte[7:6]);
                o_job.empty  = 1'b1;
                o_job.last   = 1'b1;
                o_job_push   = (i_data_byte[5:0] == 6'd0);
            end else begin
                n_bytes_left = w_left_dec;
                if (r_type == frutl_pkg::FT_ASCII6) begin
                    o_job.word = w_word_ins;
                    if (w_gcnt_inc == 2'd3 || w_last) begin
                        o_job_push = 1'b1;
                        n_word     = 24'd0;
                        n_gcnt     = 2'd0;
                    end else begin
                        n_word     = w_word_ins;
                        n_gcnt     = w_gcnt_inc;
                    end
                end else begin
                    o_job_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 6'd0;
            r_type       <= frutl_pkg::FT_BINARY;
            r_word       <= 24'd0;
            r_gcnt       <= 2'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_type       <= n_type;
            r_word       <= n_word;
            r_gcnt       <= n_gcnt;
        end
    end

endmodule

/* design/frutl_job_fifo.sv */
// Short queue of character jobs between the front end and the back end.
module frutl_job_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  frutl_pkg::t_job     i_job,
    input  logic                i_pop,
    output frutl_pkg::t_job     o_job,
    output frutl_pkg::t_q_stat  o_stat
);

    frutl_pkg::t_job                      r_mem [frutl_pkg::JOB_DEPTH];
    logic [frutl_pkg::JOB_PTR_W-1:0]      r_wp, n_wp;
    logic [frutl_pkg::JOB_PTR_W-1:0]      r_rp, n_rp;
    logic [frutl_pkg::JOB_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                 w_push;
    logic                                 w_pop;

    assign o_stat.full  = (r_cnt == frutl_pkg::JOB_CNT_W'(frutl_pkg::JOB_DEPTH));
    assign o_stat.valid = (r_cnt != '0);
    assign o_job        = r_mem[r_rp];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && o_stat.valid;

    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = w_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* design/frutl_back.sv */
// Back end: jobs become chars, one a cycle unless the two-entry output queue is full.
module frutl_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  frutl_pkg::t_job         i_job,
    input  frutl_pkg::t_q_stat      i_job_stat,
    output logic                    o_job_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic [7:0]              o_out_char,
    output logic [1:0]              o_field_type,
    output logic                    o_empty_field,
    output logic                    o_last_of_field
);

    logic [1:0]   r_idx, n_idx;
    logic [1:0]   w_last_idx;
    logic         w_emit;
    logic [7:0]   w_char;
    logic [5:0]   w_six;
    logic         w_last;

    logic [7:0]   r_ch    [2];
    logic [1:0]   r_ft    [2];
    logic         r_emp   [2];
    logic         r_lst   [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt, n_cnt;
    logic         w_out_pop;

    always_comb begin
        w_last_idx = 2'd0;
        if (!i_job.empty) begin
            case (i_job.ftype)
                frutl_pkg::FT_BINARY: w_last_idx = 2'd1;
                frutl_pkg::FT_ASCII6: w_last_idx = 2'd3;
                default:              w_last_idx = 2'd0;
            endcase
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    w_six = i_job.word[5:0];
            2'd1:    w_six = i_job.word[11:6];
            2'd2:    w_six = i_job.word[17:12];
            default: w_six = i_job.word[23:18];
        endcase
    end

    always_comb begin
        w_char = i_job.word[7:0];
        if (i_job.empty) begin
            w_char = 8'd0;
        end else begin
            case (i_job.ftype)
                frutl_pkg::FT_BINARY: begin
                    w_char = (r_idx == 2'd0) ? frutl_pkg::HEX_MAP[i_job.word[7:4]]
                                             : frutl_pkg::HEX_MAP[i_job.word[3:0]];
                end
                frutl_pkg::FT_BCD:    w_char = frutl_pkg::BCD_MAP[i_job.word[3:0]];
                frutl_pkg::FT_ASCII6: w_char = {2'b00, w_six} + frutl_pkg::CHAR_OFFSET;
                default:              w_char = i_job.word[7:0];
            endcase
        end
    end

    assign w_emit    = i_job_stat.valid && (r_cnt != 2'd2);
    assign o_job_pop = w_emit && (r_idx == w_last_idx);
    assign w_last    = (r_idx == w_last_idx) && i_job.last;
    assign n_idx     = o_job_pop ? 2'd0 : (w_emit ? r_idx + 2'd1 : r_idx);

    assign o_empty         = (r_cnt == 2'd0);
    assign w_out_pop       = i_pop && !o_empty;
    assign o_out_char      = r_ch[r_rp];
    assign o_field_type    = r_ft[r_rp];
    assign o_empty_field   = r_emp[r_rp];
    assign o_last_of_field = r_lst[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_emit && !w_out_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_out_pop && !w_emit) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ch[r_wp]  <= w_char;
            r_ft[r_wp]  <= i_job.ftype;
            r_emp[r_wp] <= i_job.empty;
            r_lst[r_wp] <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_idx <= n_idx;
            r_wp  <= w_emit ? ~r_wp : r_wp;
            r_rp  <= w_out_pop ? ~r_rp : r_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* design/fru_type_length_field_decoder.sv */
// Top level of the FRU type/length field decoder.
//
// Input side is a queue write port: a raw FRU byte on i_data_byte transfers at a
// rising edge with push high and full low. A byte with no open field is a
// type/length byte; later bytes are data bytes of that field.
// Output side is a queue read port: while empty is low the oldest character is
// on o_out_char, o_field_type, o_empty_field and o_last_of_field, and it
// transfers at a rising edge with pop high.
// A job is queued as a data byte transfers, but a six-bit field queues one per
// three bytes or at its last byte, and an empty field's type/length byte queues
// one. The back end writes one character per cycle while the output queue has
// room: two per binary byte, four per six-bit group, one per other byte. A
// four-entry job queue decouples the parser from the character expander, and a
// two-entry output queue lets the block keep accepting while a result waits.
// A synchronous active-low reset empties both queues and returns the parser to
// expecting a type/length byte. When the receiver stops popping, the output
// queue fills, the job queue fills behind it, and full rises; nothing is lost.
module fru_type_length_field_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_char,
    output logic [1:0]  o_field_type,
    output logic        o_empty_field,
    output logic        o_last_of_field
);

    frutl_pkg::t_job     w_front_job;
    frutl_pkg::t_job     w_head_job;
    frutl_pkg::t_q_stat  w_job_stat;
    logic                w_job_push;
    logic                w_job_pop;
    logic                w_accept;

    assign full     = w_job_stat.full;
    assign w_accept = push && !w_job_stat.full;

    frutl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .o_job_push  (w_job_push),
        .o_job       (w_front_job)
    );

    frutl_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_front_job),
        .i_pop   (w_job_pop),
        .o_job   (w_head_job),
        .o_stat  (w_job_stat)
    );

    frutl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (w_head_job),
        .i_job_stat      (w_job_stat),
        .o_job_pop       (w_job_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_char      (o_out_char),
        .o_field_type    (o_field_type),
        .o_empty_field   (o_empty_field),
        .o_last_of_field (o_last_of_field)
    );

`include "fru_type_length_field_decoder_assert.svh"

    `FRUTL_ASSERT_NOW(a_empty_field_char, !empty && o_empty_field, o_out_char == 8'd0 && o_last_of_field, "empty field result must be a zero last character")
    `FRUTL_ASSERT_NOW(a_ascii6_range, !empty && !o_empty_field && o_field_type == frutl_pkg::FT_ASCII6, o_out_char >= 8'h20 && o_out_char <= 8'h5f, "six-bit character out of range")
    `FRUTL_ASSERT_NOW(a_hex_digit, !empty && !o_empty_field && o_field_type == frutl_pkg::FT_BINARY, (o_out_char >= 8'h30 && o_out_char <= 8'h39) || (o_out_char >= 8'h61 && o_out_char <= 8'h66), "binary field character is not a hex digit")
    `FRUTL_ASSERT_NEXT(a_job_pop_valid, w_job_pop, !$past(w_job_stat.full) || !w_job_stat.full || $past(w_job_push), "job queue popped without progress")

endmodule
